// ----- rtl/scw_pkg.sv -----
// Package for the scan cycle watchdog: command, status and state codes, constants, helpers.
`default_nettype none
package scw_pkg;

  localparam int unsigned CmdW       = 3;
  localparam int unsigned PeriodW    = 32;
  localparam int unsigned CountW     = 64;
  localparam int unsigned SkipW      = 8;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgDataW   = 32;

  localparam logic [SkipW-1:0]   MaxSkippedRst = 8'd2;
  localparam logic               WdEnableRst   = 1'b1;
  localparam logic [PeriodW-1:0] FloorRst      = 32'd1000;
  localparam logic [PeriodW-1:0] CeilRst       = 32'd1000000;

  // x / 1000 for any 32-bit x: multiply by ceil(2^38 / 1000), keep bits 63:38
  localparam logic [63:0] DivMagic = 64'd274877907;
  localparam int unsigned DivShift = 38;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK       = 3'd0,
    CMD_CYCLE_END  = 3'd1,
    CMD_START      = 3'd2,
    CMD_STOP       = 3'd3,
    CMD_SET_PERIOD = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DENIED  = 2'd1,
    ST_BADSTATE = 2'd2,
    ST_CLAMPED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    LS_CREATED = 2'd0,
    LS_RUNNING = 2'd1,
    LS_STOPPED = 2'd2,
    LS_HALTED  = 2'd3
  } loop_state_e;

  typedef enum logic [CfgIndexW-1:0] {
    REG_MAX_SKIPPED  = 2'd0,
    REG_WD_ENABLE    = 2'd1,
    REG_PERIOD_FLOOR = 2'd2,
    REG_PERIOD_CEIL  = 2'd3
  } cfg_reg_e;

  function automatic logic [PeriodW-1:0] div_by_1000(input logic [PeriodW-1:0] x);
    logic [63:0] prod;
    prod = {32'd0, x} * DivMagic;
    return {{(PeriodW - (64 - DivShift)){1'b0}}, prod[63:DivShift]};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/scw_intf.sv -----
// Handshake channel interfaces for the scan cycle watchdog: request, result and register write.
`default_nettype none
interface scw_in_if import scw_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CmdW-1:0]    cmd;
  logic               can_run;
  logic [PeriodW-1:0] period_value;

  modport source (output valid, cmd, can_run, period_value, input ready);
  modport sink   (input valid, cmd, can_run, period_value, output ready);
endinterface

interface scw_out_if import scw_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               cycle_start;
  logic [1:0]         state_out;
  logic               tripped;
  logic [CountW-1:0]  elapsed_ms;
  logic [CountW-1:0]  iterations;
  logic [PeriodW-1:0] current_period;

  modport source (output valid, status, cycle_start, state_out, tripped, elapsed_ms,
                  iterations, current_period, input ready);
  modport sink   (input valid, status, cycle_start, state_out, tripped, elapsed_ms,
                  iterations, current_period, output ready);
endinterface

interface scw_cfg_if import scw_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] reg_index;
  logic [CfgDataW-1:0]  wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

// ----- rtl/scan_cycle_watchdog.sv -----
// Scan cycle watchdog top level: command pipeline, loop state, watchdog and period control.
//
// Each request (tick, cycle_end, start, stop, set_period) gives one result by way of
// the input register, where the requested period is also divided by 1000, and then the
// result stage, into which the loop state is updated. A request is accepted every
// cycle; while a result waits to be taken, the input register takes one more request and
// then holds the input off until the result stage moves. Register writes take effect at
// once and are always accepted.
`default_nettype none
module scan_cycle_watchdog import scw_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  scw_in_if.sink     in_i,
  scw_out_if.source  out_o,
  scw_cfg_if.sink    cfg_i
);

  // configuration
  logic [SkipW-1:0]   max_skipped_q;
  logic               wd_enable_q;
  logic [PeriodW-1:0] floor_q, ceil_q, floor_ms_q, ceil_ms_q;
  logic [PeriodW-1:0] cfg_ms;

  // input register
  logic               ex_valid_q;
  cmd_e               ex_cmd_q;
  logic               ex_can_run_q;
  logic [PeriodW-1:0] ex_req_q, ex_req_ms_q;

  // loop state
  loop_state_e        loop_state_q, loop_state_d;
  logic               cycle_done_q, cycle_done_d;
  logic [SkipW-1:0]   skip_count_q, skip_count_d;
  logic               wd_flag_q, wd_flag_d;
  logic [PeriodW-1:0] period_q, period_d, period_ms_q, period_ms_d;
  logic [CountW-1:0]  elapsed_q, elapsed_d, iter_q, iter_d;

  // result stage
  logic               out_valid_q;
  status_e            status_q, status_d;
  logic               cycle_start_q, cycle_start_d;

  logic               advance;
  logic [SkipW:0]     skip_next;

  assign cfg_i.ready = 1'b1;
  assign cfg_ms      = div_by_1000(cfg_i.wdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_skipped_q <= MaxSkippedRst;
      wd_enable_q   <= WdEnableRst;
      floor_q       <= FloorRst;
      ceil_q        <= CeilRst;
      floor_ms_q    <= div_by_1000(FloorRst);
      ceil_ms_q     <= div_by_1000(CeilRst);
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.reg_index))
        REG_MAX_SKIPPED:  max_skipped_q <= cfg_i.wdata[SkipW-1:0];
        REG_WD_ENABLE:    wd_enable_q   <= cfg_i.wdata[0];
        REG_PERIOD_FLOOR: begin
          floor_q    <= cfg_i.wdata;
          floor_ms_q <= cfg_ms;
        end
        REG_PERIOD_CEIL: begin
          ceil_q    <= cfg_i.wdata;
          ceil_ms_q <= cfg_ms;
        end
        default: ;
      endcase
    end
  end

  assign advance    = ex_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !ex_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      ex_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ex_cmd_q     <= cmd_e'(in_i.cmd);
      ex_can_run_q <= in_i.can_run;
      ex_req_q     <= in_i.period_value;
      ex_req_ms_q  <= div_by_1000(in_i.period_value);
    end
  end

  assign skip_next = {1'b0, skip_count_q} + {{SkipW{1'b0}}, 1'b1};

  always_comb begin
    loop_state_d  = loop_state_q;
    cycle_done_d  = cycle_done_q;
    skip_count_d  = skip_count_q;
    wd_flag_d     = wd_flag_q;
    period_d      = period_q;
    period_ms_d   = period_ms_q;
    elapsed_d     = elapsed_q;
    iter_d        = iter_q;
    status_d      = ST_OK;
    cycle_start_d = 1'b0;
    unique case (ex_cmd_q)
      CMD_TICK: begin
        if (loop_state_q == LS_RUNNING) begin
          elapsed_d = elapsed_q + {{(CountW-PeriodW){1'b0}}, period_ms_q};
          if (cycle_done_q) begin
            cycle_done_d  = 1'b0;
            skip_count_d  = '0;
            wd_flag_d     = 1'b0;
            iter_d        = iter_q + {{(CountW-1){1'b0}}, 1'b1};
            cycle_start_d = 1'b1;
          end else if (wd_enable_q) begin
            skip_count_d = skip_next[SkipW] ? {SkipW{1'b1}} : skip_next[SkipW-1:0];
            if (skip_next > {1'b0, max_skipped_q}) begin
              wd_flag_d    = 1'b1;
              loop_state_d = LS_HALTED;
            end
          end
        end
      end
      CMD_CYCLE_END: cycle_done_d = 1'b1;
      CMD_START: begin
        if (!ex_can_run_q) begin
          status_d = ST_DENIED;
        end else if (loop_state_q == LS_RUNNING) begin
          status_d = ST_BADSTATE;
        end else begin
          if (loop_state_q == LS_HALTED) begin
            wd_flag_d    = 1'b0;
            skip_count_d = '0;
          end
          loop_state_d  = LS_RUNNING;
          cycle_done_d  = 1'b0;
          cycle_start_d = 1'b1;
        end
      end
      CMD_STOP: begin
        if (loop_state_q == LS_RUNNING) begin
          loop_state_d = LS_STOPPED;
        end else begin
          status_d = ST_BADSTATE;
        end
      end
      CMD_SET_PERIOD: begin
        priority if (ex_req_q > ceil_q) begin
          period_d    = ceil_q;
          period_ms_d = ceil_ms_q;
          status_d    = ST_CLAMPED;
        end else if (ex_req_q < floor_q) begin
          period_d    = floor_q;
          period_ms_d = floor_ms_q;
          status_d    = ST_CLAMPED;
        end else begin
          period_d    = ex_req_q;
          period_ms_d = ex_req_ms_q;
        end
      end
      default: status_d = ST_BADSTATE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_state_q  <= LS_CREATED;
      cycle_done_q  <= 1'b0;
      skip_count_q  <= '0;
      wd_flag_q     <= 1'b0;
      period_q      <= FloorRst;
      period_ms_q   <= div_by_1000(FloorRst);
      elapsed_q     <= '0;
      iter_q        <= '0;
      out_valid_q   <= 1'b0;
      status_q      <= ST_OK;
      cycle_start_q <= 1'b0;
    end else begin
      if (advance) begin
        loop_state_q  <= loop_state_d;
        cycle_done_q  <= cycle_done_d;
        skip_count_q  <= skip_count_d;
        wd_flag_q     <= wd_flag_d;
        period_q      <= period_d;
        period_ms_q   <= period_ms_d;
        elapsed_q     <= elapsed_d;
        iter_q        <= iter_d;
        status_q      <= status_d;
        cycle_start_q <= cycle_start_d;
        out_valid_q   <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // state registers only move when a result enters the result stage
  assign out_o.valid          = out_valid_q;
  assign out_o.status         = status_q;
  assign out_o.cycle_start    = cycle_start_q;
  assign out_o.state_out      = loop_state_q;
  assign out_o.tripped        = wd_flag_q;
  assign out_o.elapsed_ms     = elapsed_q;
  assign out_o.iterations     = iter_q;
  assign out_o.current_period = period_q;

`ifndef NO_ASSERTIONS
  a_trip_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wd_flag_q |-> loop_state_q == LS_HALTED)
    else $error("watchdog flag set outside halted state");

  a_start_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && cycle_start_q |-> status_q == ST_OK)
    else $error("cycle start with non-ok status");

  a_iter_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_q != $past(iter_q) |-> iter_q == $past(iter_q) + 64'd1)
    else $error("iteration count moved by other than one");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> $stable(elapsed_q) && $stable(loop_state_q))
    else $error("state changed while result stalled");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ex_valid_q |-> in_i.ready)
    else $error("input stalled with empty input register");
`endif

endmodule
`default_nettype wire
